// ===== src/assert_macros.svh =====
// assertion helpers for the block checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/trs_pkg.sv =====
`default_nettype none
package trs_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned MAT_N   = 9;
   localparam int unsigned AXIS_N  = 3;
   localparam int unsigned QUAT_N  = 4;
   localparam int unsigned ISQ_LAT = 32;   // one root bit per stage
   localparam int unsigned DIV_LAT = 31;   // one quotient bit per stage
   localparam int unsigned QUO_W   = 31;   // quotient never exceeds 1.0 in q2.30
   localparam int unsigned TERM_W  = 34;   // pivot reaches 4.0 in q2.30, signed
   localparam int unsigned REQ_DATA_W = (MAT_N + AXIS_N) * WORD_W;
   localparam int unsigned RSP_DATA_W = (2 * AXIS_N + QUAT_N) * WORD_W;
   localparam logic [WORD_W-1:0] Q30_ONE = 32'h4000_0000;

   typedef logic [WORD_W-1:0] word_type;

   // classified matrix word: magnitudes and signs of the basis, translation
   typedef struct packed {
      logic [MAT_N-1:0]           neg;
      word_type [MAT_N-1:0]       mag;
      word_type [AXIS_N-1:0]      trans;
   } trs_item_type;

   // queue status seen by front and back
   typedef struct packed {
      logic not_empty;
      logic full;
   } trs_qstat_type;

endpackage
`default_nettype wire

// ===== src/trs_front.sv =====
`default_nettype none
module trs_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire logic [trs_pkg::REQ_DATA_W-1:0]  in_data,
   input  wire trs_pkg::trs_qstat_type          q_stat,
   output logic                                 q_push,
   output trs_pkg::trs_item_type                q_item
);
   import trs_pkg::*;

   logic         fv_ff, fv_in;
   trs_item_type item_ff, item_in;

   assign in_ready = !fv_ff || !q_stat.full;
   assign q_push   = fv_ff && !q_stat.full;
   assign q_item   = item_ff;

   always_comb begin
      fv_in = fv_ff;
      if (in_ready) begin
         fv_in = in_valid;
      end
   end

   // split each basis entry into sign and magnitude
   always_comb begin
      for (int e = 0; e < MAT_N; e++) begin
         item_in.neg[e] = in_data[e*WORD_W + WORD_W - 1];
         item_in.mag[e] = in_data[e*WORD_W + WORD_W - 1]
                        ? (~in_data[e*WORD_W +: WORD_W] + 32'd1)
                        : in_data[e*WORD_W +: WORD_W];
      end
      for (int a = 0; a < AXIS_N; a++) begin
         item_in.trans[a] = in_data[(MAT_N + a)*WORD_W +: WORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/trs_queue.sv =====
`default_nettype none
module trs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire trs_pkg::trs_item_type   push_item,
   input  wire logic                    pop,
   output trs_pkg::trs_item_type        pop_item,
   output trs_pkg::trs_qstat_type       stat
);
   import trs_pkg::*;

   localparam int unsigned DEPTH = 2;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   trs_item_type     ent_ff [DEPTH];

   // pointers wrap naturally, depth is a power of two
   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_comb begin
      stat.not_empty = (cnt_ff != '0);
      stat.full      = (cnt_ff == CNT_W'(DEPTH));
   end

   assign pop_item = ent_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// ===== src/trs_isqrt.sv =====
`default_nettype none
module trs_isqrt (
   input  wire logic         clock,
   input  wire logic         en,
   input  wire logic [63:0]  radicand,
   output logic [31:0]       root
);
   import trs_pkg::*;

   logic [32:0] rem_ff  [ISQ_LAT];
   logic [32:0] rem_in  [ISQ_LAT];
   logic [31:0] root_ff [ISQ_LAT];
   logic [31:0] root_in [ISQ_LAT];
   logic [63:0] rad_ff  [ISQ_LAT];
   logic [63:0] rad_in  [ISQ_LAT];

   // restoring digit recurrence, two radicand bits in per stage
   for (genvar k = 0; k < ISQ_LAT; k++) begin : g_stage
      logic [32:0] rem_src;
      logic [31:0] root_src;
      logic [63:0] rad_src;
      logic [34:0] part_w;
      logic [34:0] trial_w;
      logic [34:0] diff_w;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      always_comb begin
         part_w  = {rem_src, rad_src[63:62]};
         trial_w = {1'b0, root_src, 2'b01};
         diff_w  = part_w - trial_w;
         rad_in[k] = {rad_src[61:0], 2'b00};
         if (part_w >= trial_w) begin
            rem_in[k]  = diff_w[32:0];
            root_in[k] = {root_src[30:0], 1'b1};
         end else begin
            rem_in[k]  = part_w[32:0];
            root_in[k] = {root_src[30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root = root_ff[ISQ_LAT-1];

endmodule
`default_nettype wire

// ===== src/trs_div.sv =====
`default_nettype none
module trs_div (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [31:0]                num,
   input  wire logic [31:0]                den,
   output logic [trs_pkg::QUO_W-1:0]       quo
);
   import trs_pkg::*;

   // quotient of (num << 30) / den, valid while num <= den
   logic [31:0]      rem_ff [DIV_LAT];
   logic [31:0]      rem_in [DIV_LAT];
   logic [QUO_W-1:0] quo_ff [DIV_LAT];
   logic [QUO_W-1:0] quo_in [DIV_LAT];
   logic [31:0]      den_ff [DIV_LAT];

   for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
      logic [31:0]      rem_src;
      logic             bit_src;
      logic [QUO_W-1:0] quo_src;
      logic [31:0]      den_src;
      logic [32:0]      part_w;
      logic [32:0]      diff_w;

      if (k == 0) begin : g_first
         // top bits of the shifted dividend, then its low bit
         assign rem_src = {1'b0, num[31:1]};
         assign bit_src = num[0];
         assign quo_src = '0;
         assign den_src = den;
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign bit_src = 1'b0;
         assign quo_src = quo_ff[k-1];
         assign den_src = den_ff[k-1];
      end

      always_comb begin
         part_w = {rem_src, bit_src};
         diff_w = part_w - {1'b0, den_src};
         if (part_w >= {1'b0, den_src}) begin
            rem_in[k] = diff_w[31:0];
            quo_in[k] = {quo_src[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = part_w[31:0];
            quo_in[k] = {quo_src[QUO_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_src;
         end
      end
   end

   assign quo = quo_ff[DIV_LAT-1];

endmodule
`default_nettype wire

// ===== src/trs_back.sv =====
`default_nettype none
module trs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire trs_pkg::trs_qstat_type          q_stat,
   input  wire trs_pkg::trs_item_type           q_item,
   output logic                                 q_pop,
   input  wire logic                            out_ready,
   output logic                                 out_valid,
   output logic [trs_pkg::RSP_DATA_W-1:0]       out_data,
   output logic                                 out_degen
);
   import trs_pkg::*;

   typedef word_type [QUAT_N-1:0] quad_type;

   typedef struct packed {
      logic [MAT_N-1:0]      neg;
      word_type [AXIS_N-1:0] trans;
      word_type [AXIS_N-1:0] scale;
      logic                  degen;
   } rot_type;

   typedef struct packed {
      word_type [AXIS_N-1:0] trans;
      word_type [AXIS_N-1:0] scale;
      logic                  degen;
      logic [QUAT_N-1:0]     cneg;
   } quat_type;

   localparam logic signed [TERM_W-1:0] ONE_T = TERM_W'(Q30_ONE);

   logic en;

   logic         a_v_ff;
   trs_item_type a_item_ff;
   logic [63:0]  a_sq_ff [MAT_N];
   logic [63:0]  a_sq_in [MAT_N];

   logic         b_v_ff;
   trs_item_type b_item_ff;
   logic [63:0]  b_acc_ff [AXIS_N];
   logic [63:0]  b_acc_in [AXIS_N];

   logic [ISQ_LAT-1:0] sd1_v_ff;
   trs_item_type       sd1_ff [ISQ_LAT];
   word_type           scale_w [AXIS_N];

   rot_type            rot_in;
   logic [DIV_LAT-1:0] sd2_v_ff;
   rot_type            sd2_ff [DIV_LAT];
   logic [QUO_W-1:0]   uq_w [MAT_N];

   logic               r_v_ff;
   rot_type            r_side_ff;
   logic signed [31:0] r_ff [MAT_N];
   logic signed [31:0] r_in [MAT_N];

   logic                     t_v_ff;
   quat_type                 t_side_ff, t_side_in;
   logic signed [TERM_W-1:0] c_ff [QUAT_N];
   logic signed [TERM_W-1:0] c_in [QUAT_N];

   logic              h_v_ff;
   quat_type          h_side_ff;
   quad_type          h_ff, h_in;
   logic [TERM_W-1:0] abs_w [QUAT_N];
   logic [63:0]       hsq_ff [QUAT_N];
   logic [63:0]       hsq_in [QUAT_N];

   logic        u_v_ff;
   quat_type    u_side_ff;
   quad_type    u_half_ff;
   logic [63:0] u_acc_ff, u_acc_in;

   logic [ISQ_LAT-1:0] sd3_v_ff;
   quat_type           sd3_ff [ISQ_LAT];
   quad_type           sd3_half_ff [ISQ_LAT];
   word_type           norm_w;

   quat_type           quat_in;
   logic [DIV_LAT-1:0] sd4_v_ff;
   quat_type           sd4_ff [DIV_LAT];
   logic [QUO_W-1:0]   qq_w [QUAT_N];

   logic                  out_v_ff;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic                  out_degen_ff, out_degen_in;

   // whole pipeline moves while the output register can take a word
   assign en    = !out_v_ff || out_ready;
   assign q_pop = en && q_stat.not_empty;

   // squares of the basis magnitudes
   always_comb begin
      for (int e = 0; e < MAT_N; e++) begin
         a_sq_in[e] = q_item.mag[e] * q_item.mag[e];
      end
   end

   // column sums of squares, exact in 64 bits
   always_comb begin
      for (int a = 0; a < AXIS_N; a++) begin
         b_acc_in[a] = a_sq_ff[a*AXIS_N] + a_sq_ff[a*AXIS_N + 1] + a_sq_ff[a*AXIS_N + 2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= q_item;
         a_sq_ff   <= a_sq_in;
         b_item_ff <= a_item_ff;
         b_acc_ff  <= b_acc_in;
      end
   end

   // column norms
   for (genvar a = 0; a < AXIS_N; a++) begin : g_col_root
      trs_isqrt u_root (
         .clock    (clock),
         .en       (en),
         .radicand (b_acc_ff[a]),
         .root     (scale_w[a])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd1_ff[0] <= b_item_ff;
         for (int k = 1; k < ISQ_LAT; k++) begin
            sd1_ff[k] <= sd1_ff[k-1];
         end
      end
   end

   always_comb begin
      rot_in.neg   = sd1_ff[ISQ_LAT-1].neg;
      rot_in.trans = sd1_ff[ISQ_LAT-1].trans;
      rot_in.degen = 1'b0;
      for (int a = 0; a < AXIS_N; a++) begin
         rot_in.scale[a] = scale_w[a];
         if (scale_w[a] == '0) begin
            rot_in.degen = 1'b1;
         end
      end
   end

   // each entry divided by the norm of its column
   for (genvar e = 0; e < MAT_N; e++) begin : g_col_div
      trs_div u_div (
         .clock (clock),
         .en    (en),
         .num   (sd1_ff[ISQ_LAT-1].mag[e]),
         .den   (scale_w[e / AXIS_N]),
         .quo   (uq_w[e])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd2_ff[0] <= rot_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            sd2_ff[k] <= sd2_ff[k-1];
         end
      end
   end

   // signed rotation entries
   always_comb begin
      for (int e = 0; e < MAT_N; e++) begin
         r_in[e] = sd2_ff[DIV_LAT-1].neg[e] ? (32'd0 - {1'b0, uq_w[e]}) : {1'b0, uq_w[e]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff      <= r_in;
         r_side_ff <= sd2_ff[DIV_LAT-1];
      end
   end

   // pivot choice and raw quaternion terms
   always_comb begin
      logic signed [TERM_W-1:0] r00, r10, r20, r01, r11, r21, r02, r12, r22, tt;
      r00 = TERM_W'(r_ff[0]);
      r10 = TERM_W'(r_ff[1]);
      r20 = TERM_W'(r_ff[2]);
      r01 = TERM_W'(r_ff[3]);
      r11 = TERM_W'(r_ff[4]);
      r21 = TERM_W'(r_ff[5]);
      r02 = TERM_W'(r_ff[6]);
      r12 = TERM_W'(r_ff[7]);
      r22 = TERM_W'(r_ff[8]);
      if (r22[TERM_W-1]) begin
         if (r00 > r11) begin
            // x pivot
            tt      = ONE_T + r00 - r11 - r22;
            c_in[0] = tt;
            c_in[1] = r01 + r10;
            c_in[2] = r20 + r02;
            c_in[3] = r12 + r21;
         end else begin
            // y pivot
            tt      = ONE_T - r00 + r11 - r22;
            c_in[0] = r01 + r10;
            c_in[1] = tt;
            c_in[2] = r12 + r21;
            c_in[3] = r20 + r02;
         end
      end else begin
         tt = r00 + r11;
         if (tt[TERM_W-1]) begin
            // z pivot
            tt      = ONE_T - r00 - r11 + r22;
            c_in[0] = r20 + r02;
            c_in[1] = r12 + r21;
            c_in[2] = tt;
            c_in[3] = r01 - r10;
         end else begin
            // w pivot
            tt      = ONE_T + r00 + r11 + r22;
            c_in[0] = r12 - r21;
            c_in[1] = r20 - r02;
            c_in[2] = r01 - r10;
            c_in[3] = tt;
         end
      end
      t_side_in.trans = r_side_ff.trans;
      t_side_in.scale = r_side_ff.scale;
      t_side_in.degen = r_side_ff.degen || tt[TERM_W-1] || (tt == '0);
      for (int k = 0; k < QUAT_N; k++) begin
         t_side_in.cneg[k] = c_in[k][TERM_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff      <= c_in;
         t_side_ff <= t_side_in;
      end
   end

   // halved magnitudes keep the sum of squares inside 64 bits
   always_comb begin
      for (int k = 0; k < QUAT_N; k++) begin
         abs_w[k]  = c_ff[k][TERM_W-1] ? (TERM_W'(0) - c_ff[k]) : c_ff[k];
         h_in[k]   = abs_w[k][WORD_W:1];
         hsq_in[k] = h_in[k] * h_in[k];
      end
   end

   assign u_acc_in = hsq_ff[0] + hsq_ff[1] + hsq_ff[2] + hsq_ff[3];

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff      <= h_in;
         hsq_ff    <= hsq_in;
         h_side_ff <= t_side_ff;
         u_acc_ff  <= u_acc_in;
         u_half_ff <= h_ff;
         u_side_ff <= h_side_ff;
      end
   end

   // quaternion length
   trs_isqrt u_norm_root (
      .clock    (clock),
      .en       (en),
      .radicand (u_acc_ff),
      .root     (norm_w)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sd3_ff[0]      <= u_side_ff;
         sd3_half_ff[0] <= u_half_ff;
         for (int k = 1; k < ISQ_LAT; k++) begin
            sd3_ff[k]      <= sd3_ff[k-1];
            sd3_half_ff[k] <= sd3_half_ff[k-1];
         end
      end
   end

   always_comb begin
      quat_in       = sd3_ff[ISQ_LAT-1];
      quat_in.degen = sd3_ff[ISQ_LAT-1].degen || (norm_w == '0);
   end

   for (genvar k = 0; k < QUAT_N; k++) begin : g_quat_div
      trs_div u_div (
         .clock (clock),
         .en    (en),
         .num   (sd3_half_ff[ISQ_LAT-1][k]),
         .den   (norm_w),
         .quo   (qq_w[k])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd4_ff[0] <= quat_in;
         for (int k = 1; k < DIV_LAT; k++) begin
            sd4_ff[k] <= sd4_ff[k-1];
         end
      end
   end

   // output word: translation, scale, then w x y z from terms 3 0 1 2
   always_comb begin
      out_data_in = '0;
      out_data_in[0 +: AXIS_N*WORD_W]             = sd4_ff[DIV_LAT-1].trans;
      out_data_in[AXIS_N*WORD_W +: AXIS_N*WORD_W] = sd4_ff[DIV_LAT-1].scale;
      for (int p = 0; p < QUAT_N; p++) begin
         if (sd4_ff[DIV_LAT-1].degen) begin
            out_data_in[(2*AXIS_N + p)*WORD_W +: WORD_W] = (p == 0) ? Q30_ONE : '0;
         end else if (sd4_ff[DIV_LAT-1].cneg[(p + 3) % QUAT_N]) begin
            out_data_in[(2*AXIS_N + p)*WORD_W +: WORD_W] =
               32'd0 - {1'b0, qq_w[(p + 3) % QUAT_N]};
         end else begin
            out_data_in[(2*AXIS_N + p)*WORD_W +: WORD_W] = {1'b0, qq_w[(p + 3) % QUAT_N]};
         end
      end
      out_degen_in = sd4_ff[DIV_LAT-1].degen;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff  <= out_data_in;
         out_degen_ff <= out_degen_in;
      end
   end

   // valid bits along the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         sd1_v_ff <= '0;
         sd2_v_ff <= '0;
         r_v_ff   <= 1'b0;
         t_v_ff   <= 1'b0;
         h_v_ff   <= 1'b0;
         u_v_ff   <= 1'b0;
         sd3_v_ff <= '0;
         sd4_v_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff   <= q_stat.not_empty;
         b_v_ff   <= a_v_ff;
         sd1_v_ff <= {sd1_v_ff[ISQ_LAT-2:0], b_v_ff};
         sd2_v_ff <= {sd2_v_ff[DIV_LAT-2:0], sd1_v_ff[ISQ_LAT-1]};
         r_v_ff   <= sd2_v_ff[DIV_LAT-1];
         t_v_ff   <= r_v_ff;
         h_v_ff   <= t_v_ff;
         u_v_ff   <= h_v_ff;
         sd3_v_ff <= {sd3_v_ff[ISQ_LAT-2:0], u_v_ff};
         sd4_v_ff <= {sd4_v_ff[DIV_LAT-2:0], sd3_v_ff[ISQ_LAT-1]};
         out_v_ff <= sd4_v_ff[DIV_LAT-1];
      end
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_data_ff;
   assign out_degen = out_degen_ff;

endmodule
`default_nettype wire

// ===== src/trs_matrix_decompose_core.sv =====
// trs matrix decompose core
// splits the upper 3x4 of an affine transform (signed q16.16) into translation,
// per-axis scale (q16.16 column norms) and a unit rotation quaternion (q2.30)
// input channel req_*: one matrix per word, twelve 32-bit entries column-major
// result channel rsp_*: one result word per matrix, in order
// throughput: one matrix per cycle while rsp_tready is high, set by the
//   fully pipelined square root units (one root bit per stage) and dividers
//   (one quotient bit per stage)
// structure: a front register classifies entries into sign and magnitude,
//   a two-word queue decouples it from the back pipeline
// when rsp_tready is low the held result word stays stable and the whole back
//   pipeline freezes; the queue and the front register then fill and
//   req_tready drops once they hold three words
// a zero column norm, a non-positive pivot or a vanishing quaternion length
//   gives the identity quaternion and raises rsp_tuser
// reset (synchronous, active high) empties the queue and clears all valid bits
`default_nettype none
module trs_matrix_decompose_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // m00 m10 m20 m01 m11 m21 m02 m12 m22 m03 m13 m23, 32 bits each
   input  wire logic [trs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // trans_x trans_y trans_z scale_x scale_y scale_z quat_w quat_x quat_y quat_z
   output logic [trs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // degenerate
   output logic [0:0]                           rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready
);
   import trs_pkg::*;

   trs_qstat_type q_stat;
   trs_item_type  push_item;
   trs_item_type  pop_item;
   logic          push;
   logic          pop;
   logic          degen;

   // sign and magnitude split, input register
   trs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (req_tdata),
      .q_stat   (q_stat),
      .q_push   (push),
      .q_item   (push_item)
   );

   // short decoupling queue
   trs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   // norms, normalization, pivot and quaternion normalization
   trs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_item    (pop_item),
      .q_pop     (pop),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_degen (degen)
   );

   assign rsp_tuser = degen;

endmodule
`default_nettype wire

// ===== src/trs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module trs_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic [trs_pkg::REQ_DATA_W-1:0]  req_tdata,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [trs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [0:0]                      rsp_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready
);
   logic stall;
   logic degen_word;
   logic ident_ok;
   logic good_word;
   logic scale_ok;
   logic req_seen;

   assign stall      = rsp_tvalid && !rsp_tready;
   assign degen_word = rsp_tvalid && rsp_tuser[0];
   assign good_word  = rsp_tvalid && !rsp_tuser[0];
   assign ident_ok   = (rsp_tdata[223:192] == 32'h4000_0000) && (rsp_tdata[319:224] == 96'd0);
   assign scale_ok   = (rsp_tdata[127:96] != 32'd0) && (rsp_tdata[159:128] != 32'd0)
                    && (rsp_tdata[191:160] != 32'd0);
   assign req_seen   = req_tvalid && req_tready && (req_tdata != '0);

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // degenerate words carry the identity quaternion
   `ASSERT_SAME(a_degen_ident, clock, reset, degen_word, ident_ok)
   // a regular word has three nonzero scales
   `ASSERT_SAME(a_scale_nonzero, clock, reset, good_word, scale_ok)
   // nothing comes out right after reset, even with input traffic
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset || (reset && req_seen), !rsp_tvalid)

endmodule

bind trs_matrix_decompose_core trs_checker u_trs_checker (.*);
`default_nettype wire
